FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the synapse array sequencer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/scda_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scda_pkg
// Types and constants of the synapse conductance decay array.
// ---------------------------------------------------------------------------
package scda_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register map: register index carried in paddr[2].
  localparam logic REG_DECAY = 1'b0;

  // Reset value of the decay fraction, unsigned Q0.16.
  localparam logic [15:0] DECAY_RESET = 16'd655;

  // Width of the spike mask; sources at or above it never spike.
  localparam int MASK_W = 16;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_STEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control strobes from the sequencer to the store, datapath and top level.
  typedef struct packed {
    logic rd_en;       // read the stores at the sequencer address
    logic clr_wr;      // clearing pass writes zero at the sequencer address
    logic w_wr;        // write weight and connected flag of the request
    logic issue;       // a step read is issued this cycle
    logic spike;       // source of the issued entry spikes
    logic step_start;  // a step request is accepted
    logic out_load;    // load the result register
    logic res_read;    // result carries the read entry
    logic res_step;    // result carries the saturation flag
  } ctrl_t;

endpackage

FILE: rtl/scda_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scda_store
// Conductance memory and weight/connected memory, one shared read address
// with registered read data and one write port each.
// ---------------------------------------------------------------------------
module scda_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          g_we,
  input  logic [AW-1:0] g_waddr,
  input  logic [31:0]   g_wdata,
  input  logic          wc_we,
  input  logic [AW-1:0] wc_waddr,
  input  logic [32:0]   wc_wdata,
  output logic [31:0]   g_rdata,
  output logic [32:0]   wc_rdata
);

  logic [31:0] g_mem  [DEPTH];
  logic [32:0] wc_mem [DEPTH];

  // Conductance memory.
  always_ff @(posedge clk) begin
    if (g_we) begin
      g_mem[g_waddr] <= g_wdata;
    end
    if (rd_en) begin
      g_rdata <= g_mem[rd_addr];
    end
  end

  // Weight memory with the connected flag in the top bit.
  always_ff @(posedge clk) begin
    if (wc_we) begin
      wc_mem[wc_waddr] <= wc_wdata;
    end
    if (rd_en) begin
      wc_rdata <= wc_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/scda_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scda_update
// Decay pipeline: multiply the read conductance by the decay fraction,
// then subtract, add the weight on a spike, saturate and write back.
// ---------------------------------------------------------------------------
module scda_update #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          issue,
  input  logic          spike,
  input  logic [AW-1:0] addr,
  input  logic          step_start,
  input  logic [31:0]   g_rdata,
  input  logic [31:0]   w_rdata,
  input  logic [15:0]   decay,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [31:0]   wr_data,
  output logic          busy,
  output logic          sat_any
);

  logic               s1_valid;
  logic               s1_spike;
  logic [AW-1:0]      s1_addr;
  logic               s2_valid;
  logic               s2_spike;
  logic [AW-1:0]      s2_addr;
  logic signed [48:0] s2_prod;
  logic signed [48:0] prod_next;
  logic [31:0]        s2_g;
  logic [31:0]        s2_w;
  logic [32:0]        q;
  logic [34:0]        sum;
  logic               clip;

  // Stage one waits for the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
    s1_spike <= spike;
    s1_addr  <= addr;
  end

  // Signed conductance times unsigned fraction, exact 49-bit product.
  assign prod_next = $signed(g_rdata) * $signed({1'b0, decay});

  // Stage two holds the product and the operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_prod  <= prod_next;
    s2_g     <= g_rdata;
    s2_w     <= w_rdata;
    s2_spike <= s1_spike;
    s2_addr  <= s1_addr;
  end

  // Floor of the product in Q16.16, then the Euler update on 35 bits.
  always_comb begin
    q   = s2_prod[48:16];
    sum = {{3{s2_g[31]}}, s2_g} - {{2{q[32]}}, q};
    if (s2_spike) begin
      sum = sum + {{3{s2_w[31]}}, s2_w};
    end
    clip = !((sum[34:31] == 4'b0000) || (sum[34:31] == 4'b1111));
    if (!clip) begin
      wr_data = sum[31:0];
    end else if (sum[34]) begin
      wr_data = 32'h8000_0000;
    end else begin
      wr_data = 32'h7FFF_FFFF;
    end
  end

  assign wr_en   = s2_valid;
  assign wr_addr = s2_addr;
  assign busy    = s1_valid || s2_valid;

  // Sticky saturation flag for the current step.
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_any <= 1'b0;
    end else if (step_start) begin
      sat_any <= 1'b0;
    end else if (s2_valid && clip) begin
      sat_any <= 1'b1;
    end
  end

endmodule

FILE: rtl/scda_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// scda_ctrl
// Request sequencer: clearing pass after reset, request capture, entry
// sweep for steps, and hand-off of the result to the output register.
// ---------------------------------------------------------------------------
module scda_ctrl #(
  parameter int N_SOURCE = 16,
  parameter int N_DEST   = 16,
  parameter int AW       = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [3:0]           src_index,
  input  logic [3:0]           dst_index,
  input  logic [31:0]          weight_in,
  input  logic                 connected_in,
  input  logic [15:0]          spike_mask,
  input  logic                 out_free,
  input  logic                 upd_busy,
  output scda_pkg::ctrl_t      ctl,
  output logic [AW-1:0]        addr,
  output logic [31:0]          item_weight,
  output logic                 item_conn
);

  localparam int N_ENTRIES = N_SOURCE * N_DEST;
  localparam int SW = (N_SOURCE > 1) ? $clog2(N_SOURCE) : 1;
  localparam int DW = (N_DEST > 1) ? $clog2(N_DEST) : 1;
  localparam logic [AW-1:0] LAST     = AW'(N_ENTRIES - 1);
  localparam logic [DW-1:0] DST_LAST = DW'(N_DEST - 1);

  scda_pkg::state_t state;
  scda_pkg::state_t state_next;

  logic [AW-1:0] cnt;
  logic [SW-1:0] src_cnt;
  logic [DW-1:0] dst_cnt;
  logic [1:0]    item_op;
  logic          item_in_range;
  logic [AW-1:0] item_idx;
  logic [15:0]   item_mask;
  logic          accept;
  logic          in_range;
  logic [31:0]   idx_wide;
  logic [6:0]    src_wide;

  assign accept = in_valid && !in_stall;

  // Entry address and range check of the incoming request.
  assign in_range = (32'(src_index) < 32'(N_SOURCE)) && (32'(dst_index) < 32'(N_DEST));
  assign idx_wide = 32'(src_index) * 32'(N_DEST) + 32'(dst_index);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scda_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      scda_pkg::ST_CLEAR: begin
        if (cnt == LAST) state_next = scda_pkg::ST_IDLE;
      end
      scda_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            scda_pkg::OP_WRITE: state_next = scda_pkg::ST_WRITE;
            scda_pkg::OP_STEP:  state_next = scda_pkg::ST_STEP;
            scda_pkg::OP_READ:  state_next = scda_pkg::ST_READ;
            default:            state_next = scda_pkg::ST_DONE;
          endcase
        end
      end
      scda_pkg::ST_WRITE: state_next = scda_pkg::ST_DONE;
      scda_pkg::ST_READ:  state_next = scda_pkg::ST_DONE;
      scda_pkg::ST_STEP: begin
        if (cnt == LAST) state_next = scda_pkg::ST_DRAIN;
      end
      scda_pkg::ST_DRAIN: begin
        if (!upd_busy) state_next = scda_pkg::ST_DONE;
      end
      scda_pkg::ST_DONE: begin
        if (out_free) state_next = scda_pkg::ST_IDLE;
      end
      default: state_next = scda_pkg::ST_CLEAR;
    endcase
  end

  // Spike of the source row under the sweep.
  assign src_wide = 7'(src_cnt);

  // Outputs.
  always_comb begin
    in_stall       = (state != scda_pkg::ST_IDLE);
    ctl.rd_en      = (state == scda_pkg::ST_STEP)
                     || ((state == scda_pkg::ST_READ) && item_in_range);
    ctl.clr_wr     = (state == scda_pkg::ST_CLEAR);
    ctl.w_wr       = (state == scda_pkg::ST_WRITE) && item_in_range;
    ctl.issue      = (state == scda_pkg::ST_STEP);
    ctl.spike      = (src_wide < 7'(scda_pkg::MASK_W)) && item_mask[src_wide[3:0]];
    ctl.step_start = accept && (opcode == scda_pkg::OP_STEP);
    ctl.out_load   = (state == scda_pkg::ST_DONE) && out_free;
    ctl.res_read   = (item_op == scda_pkg::OP_READ) && item_in_range;
    ctl.res_step   = (item_op == scda_pkg::OP_STEP);
    if ((state == scda_pkg::ST_CLEAR) || (state == scda_pkg::ST_STEP)) begin
      addr = cnt;
    end else begin
      addr = item_idx;
    end
  end

  // Sweep counters for the clearing pass and the step.
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      cnt     <= '0;
      src_cnt <= '0;
      dst_cnt <= '0;
    end else if (ctl.clr_wr || ctl.issue) begin
      cnt <= cnt + 1'b1;
      if (ctl.issue) begin
        if (dst_cnt == DST_LAST) begin
          dst_cnt <= '0;
          src_cnt <= src_cnt + 1'b1;
        end else begin
          dst_cnt <= dst_cnt + 1'b1;
        end
      end
    end
  end

  // Captured request.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op       <= opcode;
      item_in_range <= in_range;
      item_idx      <= idx_wide[AW-1:0];
      item_weight   <= weight_in;
      item_conn     <= connected_in;
      item_mask     <= spike_mask;
    end
  end

  // A request is never taken twice in a row; results wait for an empty pipe;
  // sweeps stay inside the store.
  `ASSERT_NEXT(a_accept_then_stall, clk, rst, accept, in_stall)
  `ASSERT_IMPLY(a_load_pipe_empty, clk, rst, ctl.out_load, !upd_busy)
  `ASSERT_IMPLY(a_sweep_in_store, clk, rst, ctl.clr_wr || ctl.issue, cnt <= LAST)

endmodule

FILE: rtl/synapse_conductance_decay_array.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// synapse_conductance_decay_array
// Source-by-destination synapse matrix with Euler exponential conductance
// decay, entry write and entry read requests.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall   opcode, src_index, dst_index, weight_in,
//                                 connected_in, spike_mask
//  out      out_valid / out_stall conductance_out, weight_out, connected_out,
//                                 saturated
//  cfg      APB psel/penable      paddr, pwdata, prdata (decay_fraction)
//
//  After reset a clearing pass zeroes the stores and holds in_stall high.
//  A step result is loaded after a sweep of one read-modify-write per cycle
//  and the pipeline drain; writes and reads pass through their own state,
//  and the next request can be taken in the cycle after the result is loaded.
//  A stalled result waits in the output register while the next request runs.
// ---------------------------------------------------------------------------
module synapse_conductance_decay_array #(
  parameter int N_SOURCE = 16,
  parameter int N_DEST   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  src_index,
  input  logic [3:0]  dst_index,
  input  logic [31:0] weight_in,
  input  logic        connected_in,
  input  logic [15:0] spike_mask,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] conductance_out,
  output logic [31:0] weight_out,
  output logic        connected_out,
  output logic        saturated,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N_ENTRIES = N_SOURCE * N_DEST;
  localparam int AW = (N_ENTRIES > 1) ? $clog2(N_ENTRIES) : 1;

  scda_pkg::ctrl_t ctl;
  logic [AW-1:0]   addr;
  logic [31:0]     item_weight;
  logic            item_conn;
  logic            out_free;
  logic            upd_busy;
  logic            upd_wr_en;
  logic [AW-1:0]   upd_wr_addr;
  logic [31:0]     upd_wr_data;
  logic            sat_any;
  logic [31:0]     g_rdata;
  logic [32:0]     wc_rdata;
  logic            g_we;
  logic [AW-1:0]   g_waddr;
  logic [31:0]     g_wdata;
  logic [32:0]     wc_wdata;
  logic [15:0]     decay_fraction;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_fraction <= scda_pkg::DECAY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == scda_pkg::REG_DECAY)) begin
      decay_fraction <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == scda_pkg::REG_DECAY) begin
      prdata = {16'd0, decay_fraction};
    end else begin
      prdata = 32'd0;
    end
  end

  // Sequencer.
  scda_ctrl #(
    .N_SOURCE (N_SOURCE),
    .N_DEST   (N_DEST),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .src_index    (src_index),
    .dst_index    (dst_index),
    .weight_in    (weight_in),
    .connected_in (connected_in),
    .spike_mask   (spike_mask),
    .out_free     (out_free),
    .upd_busy     (upd_busy),
    .ctl          (ctl),
    .addr         (addr),
    .item_weight  (item_weight),
    .item_conn    (item_conn)
  );

  // Write port selection: the clearing pass wins over normal traffic.
  assign g_we     = ctl.clr_wr || upd_wr_en;
  assign g_waddr  = ctl.clr_wr ? addr : upd_wr_addr;
  assign g_wdata  = ctl.clr_wr ? 32'd0 : upd_wr_data;
  assign wc_wdata = ctl.clr_wr ? 33'd0 : {item_conn, item_weight};

  scda_store #(
    .DEPTH (N_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rd_en    (ctl.rd_en),
    .rd_addr  (addr),
    .g_we     (g_we),
    .g_waddr  (g_waddr),
    .g_wdata  (g_wdata),
    .wc_we    (ctl.clr_wr || ctl.w_wr),
    .wc_waddr (addr),
    .wc_wdata (wc_wdata),
    .g_rdata  (g_rdata),
    .wc_rdata (wc_rdata)
  );

  // Decay datapath.
  scda_update #(
    .AW (AW)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .issue      (ctl.issue),
    .spike      (ctl.spike),
    .addr       (addr),
    .step_start (ctl.step_start),
    .g_rdata    (g_rdata),
    .w_rdata    (wc_rdata[31:0]),
    .decay      (decay_fraction),
    .wr_en      (upd_wr_en),
    .wr_addr    (upd_wr_addr),
    .wr_data    (upd_wr_data),
    .busy       (upd_busy),
    .sat_any    (sat_any)
  );

  // Result register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      conductance_out <= ctl.res_read ? g_rdata : 32'd0;
      weight_out      <= ctl.res_read ? wc_rdata[31:0] : 32'd0;
      connected_out   <= ctl.res_read && wc_rdata[32];
      saturated       <= ctl.res_step && sat_any;
    end
  end

endmodule

FILE: bench/synapse_array_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// synapse_array_checker
// Watches the request, result and configuration channels of the synapse
// conductance decay array. It keeps its own copy of the synapse matrix and
// of the decay fraction, works out the result of every accepted request,
// and compares each accepted result field by field with the oldest one.
// ---------------------------------------------------------------------------
module synapse_array_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [3:0]  src_index,
  input  logic [3:0]  dst_index,
  input  logic [31:0] weight_in,
  input  logic        connected_in,
  input  logic [15:0] spike_mask,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] conductance_out,
  input  logic [31:0] weight_out,
  input  logic        connected_out,
  input  logic        saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          readouts_owed,
  output int          mismatches
);

  localparam int N_SOURCE = 16;
  localparam int N_DEST   = 16;
  localparam int N_SYN    = N_SOURCE * N_DEST;
  localparam longint G_MAX = 64'sd2147483647;
  localparam longint G_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] conductance;
    logic [31:0] weight;
    logic        connected;
    logic        saturated;
  } response_t;

  // Shadow copy of the synapse matrix and the decay register.
  logic signed [31:0] cond_mem [N_SYN];
  logic signed [31:0] weight_mem [N_SYN];
  logic               link_mem [N_SYN];
  logic [15:0]        decay_fraction;

  response_t queued_responses [$];
  response_t oldest;

  // Applies one request to the shadow matrix and returns its result.
  function automatic response_t synapse_response(
    input logic [1:0]  op,
    input logic [3:0]  src,
    input logic [3:0]  dst,
    input logic [31:0] w,
    input logic        c,
    input logic [15:0] mask
  );
    response_t r;
    logic [7:0] idx;
    longint g;
    longint f;
    longint n;
    logic clipped;
    int k;
    r = '0;
    idx = {src, dst};
    clipped = 1'b0;
    f = longint'({48'd0, decay_fraction});
    case (op)
      scda_pkg::OP_WRITE: begin
        weight_mem[idx] = w;
        link_mem[idx] = c;
      end
      scda_pkg::OP_STEP: begin
        // Euler decay of every entry; the arithmetic shift floors the product.
        for (int s = 0; s < N_SOURCE; s++) begin
          for (int d = 0; d < N_DEST; d++) begin
            k = s * N_DEST + d;
            g = longint'(cond_mem[k]);
            n = g - ((g * f) >>> 16);
            if (s < scda_pkg::MASK_W && mask[s]) begin
              n = n + longint'(weight_mem[k]);
            end
            if (n > G_MAX) begin
              n = G_MAX;
              clipped = 1'b1;
            end else if (n < G_MIN) begin
              n = G_MIN;
              clipped = 1'b1;
            end
            cond_mem[k] = n[31:0];
          end
        end
        r.saturated = clipped;
      end
      scda_pkg::OP_READ: begin
        r.conductance = cond_mem[idx];
        r.weight = weight_mem[idx];
        r.connected = link_mem[idx];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < N_SYN; e++) begin
        cond_mem[e] = '0;
        weight_mem[e] = '0;
        link_mem[e] = 1'b0;
      end
      decay_fraction = scda_pkg::DECAY_RESET;
      queued_responses.delete();
      readouts_owed <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (queued_responses.size() == 0) begin
          $error("result with no request outstanding: conductance 0x%08h", conductance_out);
          mismatches++;
        end else begin
          oldest = queued_responses.pop_front();
          check_field("conductance_out", oldest.conductance, conductance_out);
          check_field("weight_out", oldest.weight, weight_out);
          check_field("connected_out", 32'(oldest.connected), 32'(connected_out));
          check_field("saturated", 32'(oldest.saturated), 32'(saturated));
        end
      end
      if (in_valid && !in_stall) begin
        queued_responses.push_back(synapse_response(opcode, src_index, dst_index,
                                                     weight_in, connected_in,
                                                     spike_mask));
      end
      if (psel && penable && pwrite && pready && paddr[2] == scda_pkg::REG_DECAY) begin
        decay_fraction = pwdata[15:0];
      end
      readouts_owed <= queued_responses.size();
    end
  end

endmodule

FILE: bench/tb_synapse_conductance_decay_array.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_synapse_conductance_decay_array
// Drives the synapse conductance decay array with a short directed sequence
// and then with random bursts of writes, time steps and reads under several
// decay fractions, with random idling on both channels. The checker beside
// the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_synapse_conductance_decay_array;

  // Opcode that the block leaves unused.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = scda_pkg::OP_WRITE;
  logic [3:0]  src_index = '0;
  logic [3:0]  dst_index = '0;
  logic [31:0] weight_in = '0;
  logic        connected_in = 1'b0;
  logic [15:0] spike_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] conductance_out;
  logic [31:0] weight_out;
  logic        connected_out;
  logic        saturated;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   readouts_owed;
  int   mismatches;
  int   items_sent = 0;
  logic quiet = 1'b0;

  synapse_conductance_decay_array dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .src_index(src_index), .dst_index(dst_index),
    .weight_in(weight_in), .connected_in(connected_in), .spike_mask(spike_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .conductance_out(conductance_out), .weight_out(weight_out),
    .connected_out(connected_out), .saturated(saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  synapse_array_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .src_index(src_index), .dst_index(dst_index),
    .weight_in(weight_in), .connected_in(connected_in), .spike_mask(spike_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .conductance_out(conductance_out), .weight_out(weight_out),
    .connected_out(connected_out), .saturated(saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .readouts_owed(readouts_owed), .mismatches(mismatches)
  );

  always #2 clk = ~clk;

  // The result side stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  // Offers one request, after a random idle gap, and holds it until taken.
  task automatic send_request(input logic [1:0] op, input logic [3:0] src,
                              input logic [3:0] dst, input logic [31:0] w,
                              input logic c, input logic [15:0] mask);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    opcode <= op;
    src_index <= src;
    dst_index <= dst;
    weight_in <= w;
    connected_in <= c;
    spike_mask <= mask;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Lets every outstanding request finish so the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readouts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_decay(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {scda_pkg::REG_DECAY, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Weights lean toward the extremes so that steps saturate now and then.
  function automatic logic [31:0] pick_weight();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(262143)) - 32'd131072;
      2: return 32'h7FFF_0000 | 32'($urandom_range(65535));
      default: return 32'h8000_0000 | 32'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(3))
      0: return 16'hFFFF;
      1: return 16'($urandom);
      2: return 16'(1) << $urandom_range(15);
      default: return 16'h0000;
    endcase
  endfunction

  // A few entry writes, one or two steps, then reads mostly of those entries.
  task automatic run_burst();
    logic [7:0] spots [4];
    int nwr;
    int nrd;
    int nstep;
    int pick;
    nwr = $urandom_range(1, 4);
    nrd = $urandom_range(1, 4);
    nstep = $urandom_range(1, 2);
    for (int i = 0; i < 4; i++) spots[i] = 8'($urandom);
    for (int i = 0; i < nwr; i++) begin
      send_request(scda_pkg::OP_WRITE, spots[i][7:4], spots[i][3:0], pick_weight(),
                   1'($urandom), 16'($urandom));
    end
    for (int i = 0; i < nstep; i++) begin
      send_request(scda_pkg::OP_STEP, 4'($urandom), 4'($urandom), $urandom,
                   1'($urandom), pick_mask());
    end
    for (int i = 0; i < nrd; i++) begin
      pick = $urandom_range(nwr - 1);
      if ($urandom_range(3) == 0) begin
        send_request(scda_pkg::OP_READ, 4'($urandom), 4'($urandom), $urandom,
                     1'($urandom), 16'($urandom));
      end else begin
        send_request(scda_pkg::OP_READ, spots[pick][7:4], spots[pick][3:0], $urandom,
                     1'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset decay fraction.
    send_request(scda_pkg::OP_READ, 4'd0, 4'd0, 32'h0, 1'b0, 16'h0);
    send_request(scda_pkg::OP_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1, 16'h0);
    send_request(scda_pkg::OP_WRITE, 4'd15, 4'd15, 32'h8000_0000, 1'b0, 16'hFFFF);
    send_request(scda_pkg::OP_WRITE, 4'd3, 4'd7, 32'h0001_0000, 1'b1, 16'h0);
    send_request(scda_pkg::OP_WRITE, 4'd15, 4'd0, 32'hFFFF_FFFF, 1'b1, 16'h0);
    // The first full step loads the weights, the second clips both ways.
    send_request(scda_pkg::OP_STEP, 4'd0, 4'd0, 32'h0, 1'b0, 16'hFFFF);
    send_request(scda_pkg::OP_STEP, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_request(scda_pkg::OP_READ, 4'd0, 4'd0, 32'h0, 1'b0, 16'h0);
    send_request(scda_pkg::OP_READ, 4'd15, 4'd15, 32'h0, 1'b0, 16'h0);
    send_request(scda_pkg::OP_READ, 4'd3, 4'd7, 32'h0, 1'b0, 16'h0);
    send_request(scda_pkg::OP_READ, 4'd15, 4'd0, 32'h0, 1'b0, 16'h0);
    // Only the top source spikes; negative values floor toward minus infinity.
    send_request(scda_pkg::OP_STEP, 4'd0, 4'd0, 32'h0, 1'b0, 16'h8000);
    send_request(scda_pkg::OP_READ, 4'd15, 4'd0, 32'h0, 1'b0, 16'h0);
    // The unused opcode changes nothing and returns zeros.
    send_request(OP_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_request(scda_pkg::OP_READ, 4'd3, 4'd7, 32'h0, 1'b0, 16'h0);
    drain();

    // Strongest decay with no spikes.
    write_decay(16'hFFFF);
    send_request(scda_pkg::OP_STEP, 4'd0, 4'd0, 32'h0, 1'b0, 16'h0000);
    send_request(scda_pkg::OP_READ, 4'd0, 4'd0, 32'h0, 1'b0, 16'h0);
    send_request(scda_pkg::OP_READ, 4'd15, 4'd15, 32'h0, 1'b0, 16'h0);
    drain();

    // No decay at all, one source spiking.
    write_decay(16'h0000);
    send_request(scda_pkg::OP_STEP, 4'd0, 4'd0, 32'h0, 1'b0, 16'h0008);
    send_request(scda_pkg::OP_READ, 4'd3, 4'd7, 32'h0, 1'b0, 16'h0);
    send_request(scda_pkg::OP_READ, 4'd0, 4'd0, 32'h0, 1'b0, 16'h0);
    drain();

    // Random part: six phases, each under its own decay fraction.
    target = items_sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_decay(16'hFFFF);
        1: write_decay(16'h0000);
        3: write_decay(scda_pkg::DECAY_RESET);
        4: write_decay(16'($urandom_range(1, 4000)));
        default: write_decay(16'($urandom));
      endcase
      quiet = (phase == 3);
      target += 300;
      while (items_sent < target) begin
        if ($urandom_range(99) < 80) begin
          run_burst();
        end else begin
          send_request(2'($urandom), 4'($urandom), 4'($urandom), $urandom,
                       1'($urandom), 16'($urandom));
        end
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("[synapse_conductance_decay_array] OK");
    end else begin
      $display("[synapse_conductance_decay_array] ERROR");
    end
    $finish;
  end

  // Watchdog, well above the slowest correct run.
  initial begin
    #8000000;
    $display("[synapse_conductance_decay_array] ERROR");
    $finish;
  end

endmodule
